// ----- rtl/omr_pkg.sv -----
`timescale 1ns / 1ps
package omr_pkg;

  localparam int PosW   = 32;
  localparam int CountW = 31;
  localparam int ModeW  = 4;
  localparam int IdxW   = 3;

  localparam logic [IdxW-1:0] REG_MODE       = 3'd0;
  localparam logic [IdxW-1:0] REG_STEP_X     = 3'd1;
  localparam logic [IdxW-1:0] REG_STEP_Y     = 3'd2;
  localparam logic [IdxW-1:0] REG_STEP_Z     = 3'd3;
  localparam logic [IdxW-1:0] REG_TARGET_X   = 3'd4;
  localparam logic [IdxW-1:0] REG_TARGET_Y   = 3'd5;
  localparam logic [IdxW-1:0] REG_STEP_COUNT = 3'd6;

  localparam int MODE_XY    = 0;
  localparam int MODE_DRIFT = 1;
  localparam int MODE_Z     = 2;
  localparam int MODE_ZAUTO = 3;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  localparam logic signed [PosW-1:0] SAFE_LIM_Z   = -32'sd983040000;
  localparam logic signed [PosW-1:0] SERVO_WIN_LO = 32'sd163840000;
  localparam logic signed [PosW-1:0] SERVO_WIN_HI = 32'sd327680000;

  localparam logic signed [PosW-1:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [PosW-1:0] POS_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [ModeW-1:0]         mode;
    logic signed [PosW-1:0]   step_x;
    logic signed [PosW-1:0]   step_y;
    logic signed [PosW-1:0]   step_z;
    logic signed [PosW-1:0]   target_x;
    logic signed [PosW-1:0]   target_y;
    logic [CountW-1:0]        step_count;
  } cfg_t;

  typedef struct packed {
    logic signed [PosW-1:0]   pos_x;
    logic signed [PosW-1:0]   pos_y;
    logic signed [PosW-1:0]   pos_z;
    logic signed [PosW-1:0]   z_inc;
    logic [CountW-1:0]        steps_left;
    logic [ModeW-1:0]         modes;
    logic [CountW-1:0]        drift_wait;
  } state_t;

  function automatic logic signed [PosW-1:0] sat_add(
    input logic signed [PosW-1:0] a,
    input logic signed [PosW-1:0] b
  );
    logic signed [PosW:0] s;
    s = {a[PosW-1], a} + {b[PosW-1], b};
    if (s[PosW] != s[PosW-1]) begin
      sat_add = s[PosW] ? POS_MIN : POS_MAX;
    end else begin
      sat_add = s[PosW-1:0];
    end
  endfunction

  function automatic logic signed [PosW-1:0] sat_neg(input logic signed [PosW-1:0] a);
    sat_neg = (a == POS_MIN) ? POS_MAX : -a;
  endfunction

endpackage

// ----- rtl/omr_if.sv -----
`timescale 1ns / 1ps
interface omr_in_if;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic signed [31:0]     servo_control;

  modport source (output valid, req_type, servo_control, input ready);
  modport sink (input valid, req_type, servo_control, output ready);
endinterface

interface omr_out_if;
  logic                   valid;
  logic                   ready;
  logic signed [31:0]     pos_x;
  logic signed [31:0]     pos_y;
  logic signed [31:0]     pos_z;
  logic [3:0]             modes_active;
  logic                   safety_abort;

  modport source (output valid, pos_x, pos_y, pos_z, modes_active, safety_abort,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, modes_active, safety_abort,
                output ready);
endinterface

// ----- rtl/omr_cfg.sv -----
`timescale 1ns / 1ps
module omr_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [omr_pkg::IdxW-1:0]      cfg_index,
  input  logic [omr_pkg::PosW-1:0]      cfg_data,
  output omr_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        omr_pkg::REG_MODE:       cfg.mode       <= cfg_data[omr_pkg::ModeW-1:0];
        omr_pkg::REG_STEP_X:     cfg.step_x     <= cfg_data;
        omr_pkg::REG_STEP_Y:     cfg.step_y     <= cfg_data;
        omr_pkg::REG_STEP_Z:     cfg.step_z     <= cfg_data;
        omr_pkg::REG_TARGET_X:   cfg.target_x   <= cfg_data;
        omr_pkg::REG_TARGET_Y:   cfg.target_y   <= cfg_data;
        omr_pkg::REG_STEP_COUNT: cfg.step_count <= cfg_data[omr_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/omr_step.sv -----
`timescale 1ns / 1ps
module omr_step (
  input  omr_pkg::state_t               cur,
  input  omr_pkg::cfg_t                 cfg,
  input  logic                          req_type,
  input  logic signed [omr_pkg::PosW-1:0] servo_control,
  output omr_pkg::state_t               nxt,
  output logic                          abort
);

  always_comb begin
    nxt   = cur;
    abort = 1'b0;
    if (req_type == omr_pkg::REQ_START) begin
      nxt.modes      = cfg.mode;
      nxt.steps_left = cfg.step_count;
      nxt.z_inc      = cfg.step_z;
    end else begin
      // xy ramp has priority over drift
      if (nxt.modes[omr_pkg::MODE_XY]) begin
        if (nxt.steps_left != '0) begin
          nxt.pos_x      = omr_pkg::sat_add(nxt.pos_x, cfg.step_x);
          nxt.pos_y      = omr_pkg::sat_add(nxt.pos_y, cfg.step_y);
          nxt.steps_left = nxt.steps_left - 1'b1;
        end else begin
          nxt.modes = '0;
          nxt.pos_x = cfg.target_x;
          nxt.pos_y = cfg.target_y;
        end
      end else if (nxt.modes[omr_pkg::MODE_DRIFT]) begin
        if (nxt.drift_wait != '0) begin
          nxt.drift_wait = nxt.drift_wait - 1'b1;
        end else begin
          nxt.drift_wait = nxt.steps_left;
          nxt.pos_x      = omr_pkg::sat_add(nxt.pos_x, cfg.step_x);
          nxt.pos_y      = omr_pkg::sat_add(nxt.pos_y, cfg.step_y);
          nxt.pos_z      = omr_pkg::sat_add(nxt.pos_z, nxt.z_inc);
        end
      end

      // z move has priority over z auto adjust
      if (nxt.modes[omr_pkg::MODE_Z]) begin
        if (nxt.steps_left != '0) begin
          if (nxt.z_inc > 0 && servo_control < omr_pkg::SAFE_LIM_Z) begin
            nxt.z_inc                  = '0;
            nxt.modes[omr_pkg::MODE_Z] = 1'b0;
            abort                      = 1'b1;
          end else begin
            nxt.pos_z = omr_pkg::sat_add(nxt.pos_z, nxt.z_inc);
          end
          nxt.steps_left = nxt.steps_left - 1'b1;
        end else begin
          nxt.z_inc                  = '0;
          nxt.modes[omr_pkg::MODE_Z] = 1'b0;
        end
      end else if (nxt.modes[omr_pkg::MODE_ZAUTO]) begin
        if (nxt.steps_left != '0) begin
          if (servo_control > omr_pkg::SERVO_WIN_LO) begin
            if (nxt.z_inc <= 0) begin
              nxt.z_inc = omr_pkg::sat_neg(nxt.z_inc);
            end
          end else if (nxt.z_inc > 0) begin
            nxt.z_inc = -nxt.z_inc;
          end
          if (servo_control < omr_pkg::SERVO_WIN_HI && servo_control > 0) begin
            nxt.z_inc                      = '0;
            nxt.modes[omr_pkg::MODE_ZAUTO] = 1'b0;
          end else begin
            nxt.pos_z = omr_pkg::sat_add(nxt.pos_z, nxt.z_inc);
          end
          nxt.steps_left = nxt.steps_left - 1'b1;
        end else begin
          nxt.z_inc                      = '0;
          nxt.modes[omr_pkg::MODE_ZAUTO] = 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/offset_move_ramp.sv -----
`timescale 1ns / 1ps
// each result is registered: the output register loads it from the accepted beat's step
// throughput: one beat per cycle unless a held result meets out ready low (stall);
//   state and result register update on accept, so the next beat may follow at once
// reset: synchronous rst clears configuration, ramp state and output valid
module offset_move_ramp (
  input  logic                          clk,
  input  logic                          rst,
  omr_in_if.sink                        in_ch,
  omr_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [omr_pkg::IdxW-1:0]      cfg_index,
  input  logic [omr_pkg::PosW-1:0]      cfg_data
);

  omr_pkg::cfg_t   cfg;
  omr_pkg::state_t state;
  omr_pkg::state_t state_next;
  logic            abort_next;
  logic            accept;

  omr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  omr_step u_step (
    .cur           (state),
    .cfg           (cfg),
    .req_type      (in_ch.req_type),
    .servo_control (in_ch.servo_control),
    .nxt           (state_next),
    .abort         (abort_next)
  );

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (accept) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.pos_x        <= state_next.pos_x;
      out_ch.pos_y        <= state_next.pos_y;
      out_ch.pos_z        <= state_next.pos_z;
      out_ch.modes_active <= state_next.modes;
      out_ch.safety_abort <= abort_next;
    end
  end

  a_abort_clears_z: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.safety_abort |-> !out_ch.modes_active[omr_pkg::MODE_Z])
    else $error("abort beat still shows z move active");

  a_start_no_abort: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.req_type == omr_pkg::REQ_START |=>
      out_ch.valid && !out_ch.safety_abort && out_ch.modes_active == cfg.mode)
    else $error("start beat result wrong");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_ch.valid && out_ch.modes_active == state.modes)
    else $error("result register out of step with ramp state");

endmodule

// ----- tb/omr_ramp_checker.sv -----
`timescale 1ns / 1ps
module omr_ramp_checker (
  input  logic      clk,
  input  logic      rst,
  omr_in_if         in_ch,
  omr_out_if        out_ch,
  input  logic      cfg_we,
  input  logic [omr_pkg::IdxW-1:0] cfg_index,
  input  logic [omr_pkg::PosW-1:0] cfg_data,
  output int        fail_count,
  output int        pending,
  output int        results_checked,
  output int        start_count,
  output int        abort_count
);

  localparam int MAX_REPORTS = 20;

  typedef struct packed {
    logic signed [omr_pkg::PosW-1:0] x;
    logic signed [omr_pkg::PosW-1:0] y;
    logic signed [omr_pkg::PosW-1:0] z;
    logic [omr_pkg::ModeW-1:0]       modes;
    logic                            abort;
  } ramp_beat_t;

  // programmed move
  logic [omr_pkg::ModeW-1:0]       set_mode;
  logic signed [omr_pkg::PosW-1:0] set_step_x, set_step_y, set_step_z;
  logic signed [omr_pkg::PosW-1:0] set_tgt_x, set_tgt_y;
  logic [omr_pkg::CountW-1:0]      set_count;

  // working ramp state
  logic signed [omr_pkg::PosW-1:0] ramp_x, ramp_y, ramp_z, ramp_zinc;
  logic [omr_pkg::CountW-1:0]      ramp_steps, ramp_wait;
  logic [omr_pkg::ModeW-1:0]       ramp_modes;

  ramp_beat_t expected_positions[$];
  int mismatches = 0;
  int n_checked = 0;
  int n_starts = 0;
  int n_aborts = 0;

  function automatic logic signed [omr_pkg::PosW-1:0] clamp_add(
    input logic signed [omr_pkg::PosW-1:0] a,
    input logic signed [omr_pkg::PosW-1:0] b
  );
    longint s;
    s = longint'(a) + longint'(b);
    if (s > longint'(omr_pkg::POS_MAX)) begin
      return omr_pkg::POS_MAX;
    end
    if (s < longint'(omr_pkg::POS_MIN)) begin
      return omr_pkg::POS_MIN;
    end
    return s[omr_pkg::PosW-1:0];
  endfunction

  function automatic logic signed [omr_pkg::PosW-1:0] flip_sign(
    input logic signed [omr_pkg::PosW-1:0] a
  );
    return (a == omr_pkg::POS_MIN) ? omr_pkg::POS_MAX : -a;
  endfunction

  task automatic advance_ramp(input logic kind, input logic signed [omr_pkg::PosW-1:0] ctl);
    ramp_beat_t r;
    logic aborted;
    aborted = 1'b0;
    if (kind == omr_pkg::REQ_START) begin
      ramp_modes = set_mode;
      ramp_steps = set_count;
      ramp_zinc  = set_step_z;
    end else begin
      if (ramp_modes[omr_pkg::MODE_XY]) begin
        if (ramp_steps != 0) begin
          ramp_x = clamp_add(ramp_x, set_step_x);
          ramp_y = clamp_add(ramp_y, set_step_y);
          ramp_steps = ramp_steps - 1'b1;
        end else begin
          ramp_modes = '0;
          ramp_x = set_tgt_x;
          ramp_y = set_tgt_y;
        end
      end else if (ramp_modes[omr_pkg::MODE_DRIFT]) begin
        if (ramp_wait != 0) begin
          ramp_wait = ramp_wait - 1'b1;
        end else begin
          ramp_wait = ramp_steps;
          ramp_x = clamp_add(ramp_x, set_step_x);
          ramp_y = clamp_add(ramp_y, set_step_y);
          ramp_z = clamp_add(ramp_z, ramp_zinc);
        end
      end

      if (ramp_modes[omr_pkg::MODE_Z]) begin
        if (ramp_steps != 0) begin
          if (ramp_zinc > 0 && ctl < omr_pkg::SAFE_LIM_Z) begin
            ramp_zinc = '0;
            ramp_modes[omr_pkg::MODE_Z] = 1'b0;
            aborted = 1'b1;
          end else begin
            ramp_z = clamp_add(ramp_z, ramp_zinc);
          end
          ramp_steps = ramp_steps - 1'b1;
        end else begin
          ramp_zinc = '0;
          ramp_modes[omr_pkg::MODE_Z] = 1'b0;
        end
      end else if (ramp_modes[omr_pkg::MODE_ZAUTO]) begin
        if (ramp_steps != 0) begin
          if (ctl > omr_pkg::SERVO_WIN_LO) begin
            if (ramp_zinc <= 0) begin
              ramp_zinc = flip_sign(ramp_zinc);
            end
          end else if (ramp_zinc > 0) begin
            ramp_zinc = -ramp_zinc;
          end
          // servo inside the good window ends the adjust
          if (ctl < omr_pkg::SERVO_WIN_HI && ctl > 0) begin
            ramp_zinc = '0;
            ramp_modes[omr_pkg::MODE_ZAUTO] = 1'b0;
          end else begin
            ramp_z = clamp_add(ramp_z, ramp_zinc);
          end
          ramp_steps = ramp_steps - 1'b1;
        end else begin
          ramp_zinc = '0;
          ramp_modes[omr_pkg::MODE_ZAUTO] = 1'b0;
        end
      end
    end
    r.x = ramp_x;
    r.y = ramp_y;
    r.z = ramp_z;
    r.modes = ramp_modes;
    r.abort = aborted;
    expected_positions.push_back(r);
  endtask

  task automatic note_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: %s expected %h actual %h", $time, field, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    ramp_beat_t want;
    if (rst) begin
      set_mode = '0;
      set_step_x = '0;
      set_step_y = '0;
      set_step_z = '0;
      set_tgt_x = '0;
      set_tgt_y = '0;
      set_count = '0;
      ramp_x = '0;
      ramp_y = '0;
      ramp_z = '0;
      ramp_zinc = '0;
      ramp_steps = '0;
      ramp_wait = '0;
      ramp_modes = '0;
      expected_positions.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          omr_pkg::REG_MODE:       set_mode = cfg_data[omr_pkg::ModeW-1:0];
          omr_pkg::REG_STEP_X:     set_step_x = cfg_data;
          omr_pkg::REG_STEP_Y:     set_step_y = cfg_data;
          omr_pkg::REG_STEP_Z:     set_step_z = cfg_data;
          omr_pkg::REG_TARGET_X:   set_tgt_x = cfg_data;
          omr_pkg::REG_TARGET_Y:   set_tgt_y = cfg_data;
          omr_pkg::REG_STEP_COUNT: set_count = cfg_data[omr_pkg::CountW-1:0];
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        n_checked++;
        if (out_ch.safety_abort === 1'b1) begin
          n_aborts++;
        end
        if (expected_positions.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: result beat expected none actual x=%h y=%h z=%h", $time,
                     out_ch.pos_x, out_ch.pos_y, out_ch.pos_z);
          end
        end else begin
          want = expected_positions.pop_front();
          note_field("pos_x", want.x, out_ch.pos_x);
          note_field("pos_y", want.y, out_ch.pos_y);
          note_field("pos_z", want.z, out_ch.pos_z);
          note_field("modes_active", 32'(want.modes), 32'(out_ch.modes_active));
          note_field("safety_abort", 32'(want.abort), 32'(out_ch.safety_abort));
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.req_type == omr_pkg::REQ_START) begin
          n_starts++;
        end
        advance_ramp(in_ch.req_type, in_ch.servo_control);
      end
    end
    pending         <= expected_positions.size();
    fail_count      <= mismatches;
    results_checked <= n_checked;
    start_count     <= n_starts;
    abort_count     <= n_aborts;
  end

  final begin
    if (expected_positions.size() != 0) begin
      $display("%0t: %0d results expected but never seen", $time, expected_positions.size());
    end
  end

endmodule

// ----- tb/tb_offset_move_ramp.sv -----
`timescale 1ns / 1ps
module tb_offset_move_ramp;

  localparam int TOTAL_BEATS    = 425;
  localparam int WATCHDOG_LIMIT = 1000;

  localparam logic [omr_pkg::IdxW-1:0] REG_UNUSED = 3'd7;

  localparam logic [omr_pkg::ModeW-1:0] M_XY    = 4'(1 << omr_pkg::MODE_XY);
  localparam logic [omr_pkg::ModeW-1:0] M_DRIFT = 4'(1 << omr_pkg::MODE_DRIFT);
  localparam logic [omr_pkg::ModeW-1:0] M_Z     = 4'(1 << omr_pkg::MODE_Z);
  localparam logic [omr_pkg::ModeW-1:0] M_ZAUTO = 4'(1 << omr_pkg::MODE_ZAUTO);

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [omr_pkg::IdxW-1:0] cfg_index;
  logic [omr_pkg::PosW-1:0] cfg_data;

  omr_in_if  in_ch ();
  omr_out_if out_ch ();

  int fail_count;
  int pending;
  int results_checked;
  int start_count;
  int abort_count;

  int beats_sent = 0;
  int burst_left = 0;
  int settings = 0;
  int quiet_cycles = 0;
  int stall_style = 0;
  int stall_run = 0;
  int stall_tick = 0;

  offset_move_ramp dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  omr_ramp_checker ramp_check (
    .clk             (clk),
    .rst             (rst),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .start_count     (start_count),
    .abort_count     (abort_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      stall_tick++;
      if (stall_run == 0) begin
        stall_style = $urandom_range(0, 3);
        stall_run = $urandom_range(8, 60);
      end else begin
        stall_run--;
      end
      case (stall_style)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= (stall_tick % 4 == 0);
        default: out_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_beat(input logic kind, input logic signed [31:0] servo);
    int gap;
    logic took;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.req_type <= kind;
    in_ch.servo_control <= servo;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end
    beats_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [omr_pkg::IdxW-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_move(
    input logic [3:0] m,
    input logic signed [31:0] sx, sy, sz, tx, ty,
    input logic [30:0] cnt
  );
    settle();
    write_reg(omr_pkg::REG_MODE, {28'($urandom), m});
    write_reg(omr_pkg::REG_STEP_X, sx);
    write_reg(omr_pkg::REG_STEP_Y, sy);
    write_reg(omr_pkg::REG_STEP_Z, sz);
    write_reg(omr_pkg::REG_TARGET_X, tx);
    write_reg(omr_pkg::REG_TARGET_Y, ty);
    write_reg(omr_pkg::REG_STEP_COUNT, {1'b0, cnt});
    if ($urandom_range(0, 4) == 0) begin
      write_reg(REG_UNUSED, $urandom);
    end
    settings++;
  endtask

  function automatic logic signed [31:0] pick_offset();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return omr_pkg::POS_MAX;
      2: return omr_pkg::POS_MIN;
      3, 4: return (int'($urandom_range(0, 80)) - 40) * 65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_zstep();
    logic signed [31:0] v;
    v = pick_offset();
    if (v == omr_pkg::POS_MIN) begin
      v = -omr_pkg::POS_MAX;
    end
    return v;
  endfunction

  function automatic logic [30:0] pick_count();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: return 31'($urandom_range(0, 6));
      7, 8: return 31'($urandom_range(7, 40));
      default: return ($urandom_range(0, 1) != 0) ? 31'h7FFF_FFFF : 31'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_servo();
    case ($urandom_range(0, 9))
      0: return omr_pkg::SAFE_LIM_Z + int'($urandom_range(0, 2)) - 1;
      1: return omr_pkg::SERVO_WIN_LO + int'($urandom_range(0, 2)) - 1;
      2: return omr_pkg::SERVO_WIN_HI + int'($urandom_range(0, 2)) - 1;
      3: return int'($urandom_range(0, 2)) - 1;
      4: return int'($urandom_range(1, 327679999));
      5: return omr_pkg::SAFE_LIM_Z - int'($urandom_range(1, 1000000000));
      6: return ($urandom_range(0, 1) != 0) ? omr_pkg::POS_MAX : omr_pkg::POS_MIN;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int len;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = omr_pkg::REQ_TICK;
    in_ch.servo_control = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // idle block, nothing programmed
    load_move('0, '0, '0, '0, '0, '0, '0);
    send_beat(omr_pkg::REQ_TICK, '0);
    send_beat(omr_pkg::REQ_START, '0);

    // xy move into both rails, then snap to the opposite corner
    load_move(M_XY, omr_pkg::POS_MAX, omr_pkg::POS_MIN, '0,
              omr_pkg::POS_MIN, omr_pkg::POS_MAX, 31'd2);
    send_beat(omr_pkg::REQ_START, '0);
    repeat (3) send_beat(omr_pkg::REQ_TICK, '0);

    // xy beats drift, xy and z share the step count, xy end clears z
    load_move(M_XY | M_DRIFT | M_Z, 32'sd65536, -32'sd65536, 32'sd196608,
              32'sd0, 32'sd0, 31'd4);
    send_beat(omr_pkg::REQ_START, '0);
    repeat (3) send_beat(omr_pkg::REQ_TICK, '0);

    // z beats auto adjust, safety limit edge then abort, auto adjust carries on
    load_move(M_Z | M_ZAUTO, '0, '0, 32'sd327680, '0, '0, 31'd3);
    send_beat(omr_pkg::REQ_START, '0);
    send_beat(omr_pkg::REQ_TICK, omr_pkg::SAFE_LIM_Z);
    send_beat(omr_pkg::REQ_TICK, omr_pkg::SAFE_LIM_Z - 32'sd1);
    send_beat(omr_pkg::REQ_TICK, omr_pkg::SERVO_WIN_LO + 32'sd1);

    // auto adjust: sign flips around the lower bound, stop in the good window
    load_move(M_ZAUTO, '0, '0, -32'sd2147483647, '0, '0, 31'd6);
    send_beat(omr_pkg::REQ_START, '0);
    send_beat(omr_pkg::REQ_TICK, omr_pkg::SERVO_WIN_HI);
    send_beat(omr_pkg::REQ_TICK, omr_pkg::SERVO_WIN_LO);
    send_beat(omr_pkg::REQ_TICK, 32'sd0);
    send_beat(omr_pkg::REQ_TICK, 32'sd1);
    send_beat(omr_pkg::REQ_TICK, 32'sd1);

    // drift every second tick, plus a write to an unmapped index
    load_move(M_DRIFT, 32'sd1, -32'sd1, 32'sd2, '0, '0, 31'd1);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_beat(omr_pkg::REQ_START, '0);
    repeat (4) send_beat(omr_pkg::REQ_TICK, pick_servo());

    while (beats_sent < TOTAL_BEATS) begin
      if ($urandom_range(0, 2) != 0) begin
        load_move(4'($urandom_range(0, 15)), pick_offset(), pick_offset(), pick_zstep(),
                  pick_offset(), pick_offset(), pick_count());
      end
      if ($urandom_range(0, 7) != 0) begin
        send_beat(omr_pkg::REQ_START, pick_servo());
      end
      len = $urandom_range(2, 14);
      repeat (len) begin
        if ($urandom_range(0, 9) == 0) begin
          send_beat(1'($urandom_range(0, 1)), pick_servo());
        end else begin
          send_beat(omr_pkg::REQ_TICK, pick_servo());
        end
      end
    end

    settle();
    repeat (4) @(posedge clk);
    $display("run: %0d beats sent, %0d results checked, %0d starts, %0d safety aborts",
             beats_sent, results_checked, start_count, abort_count);
    $display("run: %0d move settings loaded under mixed sender gaps and receiver stalls",
             settings);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
